@@ rtl/wdh_pkg.sv @@
// Shared types and constants for the windowed density histogram.
// Used by every module of the block; depends on nothing.
package wdh_pkg;

    localparam int DIV_BITS   = 49;  // width of step + period/2
    localparam int DIV_CNT_W  = 6;
    localparam int MAX_IDX_W  = 6;   // bin index field width
    localparam int NB_W       = 7;   // active bin count width
    localparam int FRAME_W    = 18;
    localparam int STEP_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PARTICLE = 2'd0,
        OP_STEP     = 2'd1,
        OP_FINISH   = 2'd2,
        OP_NONE     = 2'd3
    } wdh_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROUP_BITS    = 3'd0,
        REG_BOX_LOW       = 3'd1,
        REG_BIN_INVERSE   = 3'd2,
        REG_BINS_IN_USE   = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_HALF_WINDOW   = 3'd5
    } wdh_reg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] position;
        logic [31:0]        atom_group_mask;
        logic [STEP_W-1:0]  timestep;
    } wdh_in_t;

    typedef struct packed {
        logic [MAX_IDX_W-1:0] bin_index;
        logic [31:0]          bin_total;
        logic [FRAME_W-1:0]   frames_taken;
        logic [STEP_W-1:0]    window_centre;
        logic                 last;
    } wdh_out_t;

    typedef struct packed {
        logic [31:0]        group_bits;
        logic signed [31:0] box_low;
        logic [31:0]        bin_inverse;
        logic [NB_W-1:0]    bins_in_use;
        logic [31:0]        sample_period;
        logic [15:0]        half_window;
    } wdh_cfg_t;

    typedef enum logic {
        CMD_INC  = 1'b0,
        CMD_DUMP = 1'b1
    } wdh_cmd_kind_t;

    typedef struct packed {
        wdh_cmd_kind_t        kind;
        logic [MAX_IDX_W-1:0] bin;
        logic [FRAME_W-1:0]   frames;
        logic [STEP_W-1:0]    centre;
    } wdh_cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_BIN,
        F_DIV,
        F_EVAL
    } wdh_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_INC_WR,
        B_DUMP_RD,
        B_DUMP_OUT
    } wdh_back_state_t;

endpackage

@@ rtl/windowed_density_histogram_core.sv @@
// Top level of the windowed density histogram: config registers and the
// front end, command queue and back end. Depends on wdh_pkg and all wdh_* modules.
//
// Usage: input words enter on item with push/full; results leave on result
// with empty/pop, oldest first. cfg_we/cfg_index/cfg_data write a register;
// write only while the block is idle. A particle word that is binned passes
// the front-end steps difference, 32x32 multiply and range check; one that
// is not sampled or not in the group is dropped as it is accepted. The bin
// increment then reads and writes back the count in the back end,
// overlapping the next word through the two-entry command queue. A step or
// finish word runs a 49-step restoring remainder loop (one bit per cycle)
// to find the window centre, then F_EVAL decides. A dump streams results
// bin by bin (memory read, then load of the result register); with the back
// end idle the first result goes through the queue, B_IDLE, B_DUMP_RD and
// B_DUMP_OUT. When pop stays low the dump holds at the current bin and the
// queue fills, after which full stays high.
// Reset loads register defaults, clears all counts through per-bin valid
// bits (no clearing pass), empties the queue and the result register.
module windowed_density_histogram_core #(
    parameter int NUM_BINS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  wdh_pkg::wdh_in_t                   item,
    output logic                               empty,
    input  logic                               pop,
    output wdh_pkg::wdh_out_t                  result,
    input  logic                               cfg_we,
    input  logic [wdh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wdh_pkg::wdh_cfg_t cfg_reg;
    wdh_pkg::wdh_cmd_t q_in;
    wdh_pkg::wdh_cmd_t q_out;
    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_bits    <= 32'd1;
            cfg_reg.box_low       <= '0;
            cfg_reg.bin_inverse   <= 32'd65536;
            cfg_reg.bins_in_use   <= 7'd64;
            cfg_reg.sample_period <= 32'd1000;
            cfg_reg.half_window   <= 16'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wdh_pkg::REG_GROUP_BITS:    cfg_reg.group_bits    <= cfg_data;
                wdh_pkg::REG_BOX_LOW:       cfg_reg.box_low       <= $signed(cfg_data);
                wdh_pkg::REG_BIN_INVERSE:   cfg_reg.bin_inverse   <= cfg_data;
                wdh_pkg::REG_BINS_IN_USE:   cfg_reg.bins_in_use   <= cfg_data[6:0];
                wdh_pkg::REG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg_data;
                wdh_pkg::REG_HALF_WINDOW:   cfg_reg.half_window   <= cfg_data[15:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    wdh_front #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (q_wr),
        .cmd      (q_in),
        .cmd_full (q_full)
    );

    wdh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_in),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    wdh_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bins_in_use (cfg_reg.bins_in_use),
        .cmd         (q_out),
        .cmd_empty   (q_empty),
        .cmd_pop     (q_rd),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

@@ rtl/wdh_front.sv @@
// Front end: accepts words, bins particles, runs window timing for step and finish words.
// Depends on wdh_pkg; feeds commands into wdh_queue.
module wdh_front #(
    parameter int NUM_BINS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wdh_pkg::wdh_cfg_t cfg,
    input  logic              push,
    output logic              full,
    input  wdh_pkg::wdh_in_t  item,
    output logic              cmd_push,
    output wdh_pkg::wdh_cmd_t cmd,
    input  logic              cmd_full
);

    wdh_pkg::wdh_front_state_t state_reg, state_next;

    logic        sampling_reg, sampling_next;
    logic [wdh_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic        ld_valid_reg, ld_valid_next;
    logic [wdh_pkg::STEP_W-1:0]  ld_step_reg, ld_step_next;

    logic [31:0] diff_reg, diff_next;
    logic        neg_reg, neg_next;
    logic [63:0] prod_reg, prod_next;

    wdh_pkg::wdh_op_t op_reg, op_next;
    logic [wdh_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [wdh_pkg::DIV_BITS-1:0] s2_reg, s2_next;
    logic [wdh_pkg::DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] per_reg, per_next;
    logic [wdh_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [wdh_pkg::NB_W-1:0] nb;
    logic signed [32:0]       diff_full;
    logic [63:0]              shifted;
    logic                     keep;
    logic [32:0]              rem_sh;
    logic [31:0]              per_in;
    logic signed [33:0]       offset;
    logic signed [33:0]       win;
    logic                     in_win;
    logic                     dump_req;
    logic [wdh_pkg::DIV_BITS-1:0] centre_full;

    assign nb = (cfg.bins_in_use < wdh_pkg::NB_W'(NUM_BINS)) ?
                cfg.bins_in_use : wdh_pkg::NB_W'(NUM_BINS);
    assign full = (state_reg != wdh_pkg::F_IDLE);

    // Datapath helpers
    assign diff_full = {item.position[31], item.position} - {cfg.box_low[31], cfg.box_low};
    assign shifted   = prod_reg >> (2 * FRAC_BITS);
    assign keep      = neg_reg ? (cfg.bin_inverse == 32'd0) : (shifted < 64'(nb));
    assign rem_sh    = {rem_reg, dvd_reg[wdh_pkg::DIV_BITS-1]};
    assign per_in    = (cfg.sample_period == 32'd0) ? 32'd1 : cfg.sample_period;
    assign offset    = $signed({2'b00, rem_reg}) - $signed({3'b000, per_reg[31:1]});
    assign win       = $signed({18'd0, cfg.half_window});
    assign in_win    = (offset >= -win) && (offset < win);
    assign centre_full = s2_reg - {17'd0, rem_reg};

    always_comb
    begin
        priority if (op_reg == wdh_pkg::OP_STEP)
            dump_req = !in_win && (offset == win);
        else
            dump_req = in_win && (!ld_valid_reg || (ld_step_reg < step_reg));
    end

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        sampling_next = sampling_reg;
        frame_next    = frame_reg;
        ld_valid_next = ld_valid_reg;
        ld_step_next  = ld_step_reg;
        diff_next     = diff_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        s2_next       = s2_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        per_next      = per_reg;
        cnt_next      = cnt_reg;
        cmd_push      = 1'b0;
        cmd.kind      = wdh_pkg::CMD_INC;
        cmd.bin       = neg_reg ? '0 : shifted[wdh_pkg::MAX_IDX_W-1:0];
        cmd.frames    = frame_reg;
        cmd.centre    = centre_full[wdh_pkg::STEP_W-1:0];

        unique case (state_reg)
            wdh_pkg::F_IDLE:
            begin
                if (push)
                begin
                    unique case (wdh_pkg::wdh_op_t'(item.op))
                        wdh_pkg::OP_PARTICLE:
                        begin
                            // drop unless sampling and in group
                            if (sampling_reg && ((item.atom_group_mask & cfg.group_bits) != 32'd0))
                            begin
                                diff_next  = diff_full[31:0];
                                neg_next   = diff_full[32];
                                state_next = wdh_pkg::F_MUL;
                            end
                        end
                        wdh_pkg::OP_STEP, wdh_pkg::OP_FINISH:
                        begin
                            op_next    = wdh_pkg::wdh_op_t'(item.op);
                            step_next  = item.timestep;
                            per_next   = per_in;
                            s2_next    = {1'b0, item.timestep} +
                                         {18'd0, per_in[31:1]};
                            dvd_next   = {1'b0, item.timestep} +
                                         {18'd0, per_in[31:1]};
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = wdh_pkg::F_DIV;
                        end
                        wdh_pkg::OP_NONE:
                        begin
                            state_next = wdh_pkg::F_IDLE;
                        end
                        default:
                        begin
                            state_next = wdh_pkg::F_IDLE;
                        end
                    endcase
                end
            end
            wdh_pkg::F_MUL:
            begin
                prod_next  = {32'd0, diff_reg} * {32'd0, cfg.bin_inverse};
                state_next = wdh_pkg::F_BIN;
            end
            wdh_pkg::F_BIN:
            begin
                // hold until the queue takes the increment
                if (!keep)
                    state_next = wdh_pkg::F_IDLE;
                else if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = wdh_pkg::F_IDLE;
                end
            end
            wdh_pkg::F_DIV:
            begin
                // one restoring step per cycle; only the remainder is kept
                if (rem_sh >= {1'b0, per_reg})
                    rem_next = 32'(rem_sh - {1'b0, per_reg});
                else
                    rem_next = rem_sh[31:0];
                dvd_next = {dvd_reg[wdh_pkg::DIV_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wdh_pkg::DIV_CNT_W'(wdh_pkg::DIV_BITS - 1))
                    state_next = wdh_pkg::F_EVAL;
            end
            wdh_pkg::F_EVAL:
            begin
                cmd.kind = wdh_pkg::CMD_DUMP;
                if (dump_req)
                begin
                    if (!cmd_full)
                    begin
                        cmd_push      = 1'b1;
                        frame_next    = '0;
                        ld_valid_next = 1'b1;
                        ld_step_next  = step_reg;
                        sampling_next = 1'b0;
                        state_next    = wdh_pkg::F_IDLE;
                    end
                end
                else
                begin
                    if ((op_reg == wdh_pkg::OP_STEP) && in_win)
                    begin
                        sampling_next = 1'b1;
                        frame_next    = frame_reg + 1'b1;
                    end
                    else
                        sampling_next = 1'b0;
                    state_next = wdh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = wdh_pkg::F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wdh_pkg::F_IDLE;
            sampling_reg <= 1'b0;
            frame_reg    <= '0;
            ld_valid_reg <= 1'b0;
            ld_step_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sampling_reg <= sampling_next;
            frame_reg    <= frame_next;
            ld_valid_reg <= ld_valid_next;
            ld_step_reg  <= ld_step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        op_reg   <= op_next;
        step_reg <= step_next;
        s2_reg   <= s2_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        per_reg  <= per_next;
        cnt_reg  <= cnt_next;
    end

endmodule

@@ rtl/wdh_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on wdh_pkg for the command type.
module wdh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  wdh_pkg::wdh_cmd_t wr_data,
    output logic              full,
    input  logic              rd,
    output wdh_pkg::wdh_cmd_t rd_data,
    output logic              empty
);

    wdh_pkg::wdh_cmd_t slot_reg [2];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[head_reg];

    // Advance pointers on each transfer
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr && !full)
        begin
            tail_next  = ~tail_reg;
            count_next = count_next + 2'd1;
        end
        if (rd && !empty)
        begin
            head_next  = ~head_reg;
            count_next = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            slot_reg[tail_reg] <= wr_data;
    end

endmodule

@@ rtl/wdh_back.sv @@
// Back end: bin count memory, increments and dump sweeps to the result register.
// Depends on wdh_pkg; drains wdh_queue.
module wdh_back #(
    parameter int NUM_BINS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wdh_pkg::NB_W-1:0]      bins_in_use,
    input  wdh_pkg::wdh_cmd_t             cmd,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output wdh_pkg::wdh_out_t             result
);

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    wdh_pkg::wdh_back_state_t state_reg, state_next;

    logic [31:0]        mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    logic [31:0]        rd_reg;
    logic               rd_valid_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [wdh_pkg::FRAME_W-1:0] frames_reg, frames_next;
    logic [wdh_pkg::STEP_W-1:0]  centre_reg, centre_next;

    logic               out_valid_reg, out_valid_next;
    wdh_pkg::wdh_out_t  out_reg, out_next;

    logic               re;
    logic [IDX_W-1:0]   ra;
    logic               we;
    logic [IDX_W-1:0]   wa;
    logic [31:0]        wd;
    logic [wdh_pkg::NB_W-1:0] nb;
    logic [31:0]        cur;
    logic               out_free;
    logic               last_bin;

    assign nb = (bins_in_use < wdh_pkg::NB_W'(NUM_BINS)) ?
                bins_in_use : wdh_pkg::NB_W'(NUM_BINS);
    assign cur      = rd_valid_reg ? rd_reg : 32'd0;
    assign out_free = !out_valid_reg || pop;
    assign last_bin = ({{(wdh_pkg::NB_W-IDX_W){1'b0}}, idx_reg} == nb - 1'b1);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        frames_next    = frames_reg;
        centre_next    = centre_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        re             = 1'b0;
        ra             = idx_reg;
        we             = 1'b0;
        wa             = idx_reg;
        wd             = 32'd0;

        unique case (state_reg)
            wdh_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        wdh_pkg::CMD_INC:
                        begin
                            // read now, write back next cycle
                            re         = 1'b1;
                            ra         = cmd.bin[IDX_W-1:0];
                            idx_next   = cmd.bin[IDX_W-1:0];
                            state_next = wdh_pkg::B_INC_WR;
                        end
                        wdh_pkg::CMD_DUMP:
                        begin
                            frames_next = cmd.frames;
                            centre_next = cmd.centre;
                            idx_next    = '0;
                            if (nb != '0)
                                state_next = wdh_pkg::B_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = wdh_pkg::B_IDLE;
                        end
                    endcase
                end
            end
            wdh_pkg::B_INC_WR:
            begin
                we         = 1'b1;
                wd         = cur + 32'd1;
                state_next = wdh_pkg::B_IDLE;
            end
            wdh_pkg::B_DUMP_RD:
            begin
                re         = 1'b1;
                state_next = wdh_pkg::B_DUMP_OUT;
            end
            wdh_pkg::B_DUMP_OUT:
            begin
                // hold the bin until the result register frees up
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.bin_index     = wdh_pkg::MAX_IDX_W'(idx_reg);
                    out_next.bin_total     = cur;
                    out_next.frames_taken  = frames_reg;
                    out_next.window_centre = centre_reg;
                    out_next.last          = last_bin;
                    we                     = 1'b1;
                    if (last_bin)
                        state_next = wdh_pkg::B_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = wdh_pkg::B_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = wdh_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wdh_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (we)
                valid_reg[wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        frames_reg <= frames_next;
        centre_reg <= centre_next;
        out_reg    <= out_next;
        if (re)
            rd_valid_reg <= valid_reg[ra];
    end

    // Count memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_reg <= mem[ra];
    end

endmodule

@@ verif/windowed_density_histogram_core_tb.sv @@
// Self-checking testbench for windowed_density_histogram_core: directed and random
// particle, step and finish words against a built-in histogram predictor.
// Depends on wdh_pkg and the RTL of the block.
`timescale 1ns / 1ps

module windowed_density_histogram_core_tb;

    localparam int NBINS      = 64;
    localparam int CYCLE_MAX  = 1500000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    wdh_pkg::wdh_in_t item;
    logic empty;
    logic pop;
    wdh_pkg::wdh_out_t result;
    logic cfg_we;
    logic [wdh_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wdh_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state
    wdh_pkg::wdh_cfg_t cfg_m;
    logic [31:0] hist_m [NBINS];
    logic [wdh_pkg::FRAME_W-1:0] frames_m;
    logic sampling_m;
    longint dumped_at_m;

    wdh_pkg::wdh_in_t word_q [$];
    wdh_pkg::wdh_out_t dump_q [$];
    wdh_pkg::wdh_out_t exp_w;
    int errors;
    int cycles;
    bit drain_all;     // no idling on either side
    int idle_pct;
    logic full_s;

    windowed_density_histogram_core u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Reset the predictor to register defaults and cleared counts
    task automatic histo_reset();
        cfg_m.group_bits = 32'd1;
        cfg_m.box_low = '0;
        cfg_m.bin_inverse = 32'd65536;
        cfg_m.bins_in_use = 7'd64;
        cfg_m.sample_period = 32'd1000;
        cfg_m.half_window = 16'd10;
        for (int i = 0; i < NBINS; i++) hist_m[i] = '0;
        frames_m = '0;
        sampling_m = 1'b0;
        dumped_at_m = -1;
    endtask

    function automatic int live_bins();
        return (cfg_m.bins_in_use < NBINS) ? int'(cfg_m.bins_in_use) : NBINS;
    endfunction

    // Emit one expected word per active bin, then clear
    task automatic predict_dump(logic [wdh_pkg::STEP_W-1:0] centre, longint step);
        wdh_pkg::wdh_out_t w;
        int nb;
        nb = live_bins();
        for (int i = 0; i < nb; i++)
        begin
            w.bin_index = i[wdh_pkg::MAX_IDX_W-1:0];
            w.bin_total = hist_m[i];
            w.frames_taken = frames_m;
            w.window_centre = centre;
            w.last = (i + 1 == nb);
            dump_q.push_back(w);
            hist_m[i] = '0;
        end
        dumped_at_m = step;
        frames_m = '0;
    endtask

    task automatic predict_particle(wdh_pkg::wdh_in_t it);
        logic signed [32:0] diff;
        logic [64:0] prod;
        logic [63:0] bin;
        if ((it.atom_group_mask & cfg_m.group_bits) == 0) return;
        diff = 33'(it.position) - 33'(cfg_m.box_low);
        if (diff < 0)
        begin
            if (cfg_m.bin_inverse != 0) return;
            bin = 0;
        end
        else
        begin
            prod = 65'(unsigned'(diff)) * 65'(cfg_m.bin_inverse);
            if (prod[64]) return;
            bin = 64'(prod[63:32]);
        end
        if (bin >= 64'(live_bins())) return;
        hist_m[bin] = hist_m[bin] + 32'd1;
    endtask

    // Advance the predictor by one accepted word
    task automatic predict_word(wdh_pkg::wdh_in_t it);
        longint unsigned period, centre, step;
        longint d, w;
        case (wdh_pkg::wdh_op_t'(it.op))
            wdh_pkg::OP_PARTICLE: if (sampling_m) predict_particle(it);
            wdh_pkg::OP_NONE: ;
            default:
            begin
                step = 64'(it.timestep);
                period = (cfg_m.sample_period == 0) ? 1 : 64'(cfg_m.sample_period);
                centre = ((step + period / 2) / period) * period;
                d = longint'(step) - longint'(centre);
                w = longint'(cfg_m.half_window);
                if (wdh_pkg::wdh_op_t'(it.op) == wdh_pkg::OP_STEP)
                begin
                    if (d >= -w && d < w)
                    begin
                        sampling_m = 1'b1;
                        frames_m = frames_m + 1'b1;
                    end
                    else
                    begin
                        sampling_m = 1'b0;
                        if (d == w)
                            predict_dump(centre[wdh_pkg::STEP_W-1:0], longint'(step));
                    end
                end
                else
                begin
                    sampling_m = 1'b0;
                    if (d >= -w && d < w && dumped_at_m < longint'(step))
                        predict_dump(centre[wdh_pkg::STEP_W-1:0], longint'(step));
                end
            end
        endcase
    endtask

    // Driver: present queued words, idle at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full_s)
            begin
                predict_word(item);
                void'(word_q.pop_front());
            end
            if (word_q.size() > 0 && (drain_all || $urandom_range(99) >= idle_pct))
            begin
                push <= 1'b1;
                item <= word_q[0];
            end
            else
                push <= 1'b0;
        end
    end

    // Sample full at the rising edge so acceptance is judged by the edge values
    always @(posedge clk)
    begin
        full_s <= full;
    end

    // Monitor: compare each popped word with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (dump_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %p", $time, result);
            end
            else
            begin
                exp_w = dump_q.pop_front();
                if (exp_w !== result)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp_w, result);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        pop <= rst_n && (drain_all || $urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(wdh_pkg::wdh_reg_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wdh_pkg::REG_GROUP_BITS: cfg_m.group_bits = val;
            wdh_pkg::REG_BOX_LOW: cfg_m.box_low = val;
            wdh_pkg::REG_BIN_INVERSE: cfg_m.bin_inverse = val;
            wdh_pkg::REG_BINS_IN_USE: cfg_m.bins_in_use = val[wdh_pkg::NB_W-1:0];
            wdh_pkg::REG_SAMPLE_PERIOD: cfg_m.sample_period = val;
            default: cfg_m.half_window = val[15:0];
        endcase
    endtask

    // Wait until every queued word is taken and every result has arrived
    task automatic settle();
        while (word_q.size() > 0 || push) @(negedge clk);
        while (dump_q.size() > 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic wdh_pkg::wdh_in_t mk(wdh_pkg::wdh_op_t op, logic [31:0] pos,
                                            logic [31:0] msk,
                                            logic [wdh_pkg::STEP_W-1:0] st);
        wdh_pkg::wdh_in_t it;
        it.op = op;
        it.position = pos;
        it.atom_group_mask = msk;
        it.timestep = st;
        return it;
    endfunction

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    function automatic logic [wdh_pkg::STEP_W-1:0] rnd48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // One well-formed window: steps inside, particles, then a dumping step or a finish word
    task automatic queue_window(longint unsigned m, int nparts);
        longint unsigned w;
        w = cfg_m.half_window;
        for (longint unsigned s = m - w; s < m + w && s < m - w + 3; s++)
        begin
            word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, s[wdh_pkg::STEP_W-1:0]));
            for (int k = 0; k < nparts; k++)
                word_q.push_back(mk(wdh_pkg::OP_PARTICLE, rnd32() & 32'h003F_FFFF |
                    ($urandom_range(9) == 0 ? rnd32() : 32'd0), rnd32() | 32'd1, rnd48()));
        end
        if ($urandom_range(3) == 0)
            word_q.push_back(mk(wdh_pkg::OP_FINISH, '0, '0, 48'(m - w + 4)));
        else
            word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'(m + w)));
    endtask

    initial
    begin
        int phase;
        longint unsigned m;
        errors = 0;
        cycles = 0;
        idle_pct = 21;
        drain_all = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        histo_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every op, zero bins, zero period, steps near the top of the range
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd995));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h0000_0000, 32'hFFFF_FFFF, '0));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h003F_FFFF, 32'h0000_0001, '1));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h0040_0000, 32'h0000_0001, '0));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h8000_0000, 32'h0000_0001, '0));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h0001_0000, 32'h0000_0002, '0));
        word_q.push_back(mk(wdh_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd1009));
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd1010));
        word_q.push_back(mk(wdh_pkg::OP_FINISH, '0, '0, 48'd1005));
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'hFFFF_FFFF_FFF0));
        word_q.push_back(mk(wdh_pkg::OP_FINISH, '0, '0, 48'd2000));
        word_q.push_back(mk(wdh_pkg::OP_FINISH, '0, '0, 48'd2000));
        settle();

        write_reg(wdh_pkg::REG_BINS_IN_USE, 32'd0);
        write_reg(wdh_pkg::REG_SAMPLE_PERIOD, 32'd0);
        write_reg(wdh_pkg::REG_HALF_WINDOW, 32'd0);
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd7));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'd5, 32'd1, '0));
        word_q.push_back(mk(wdh_pkg::OP_FINISH, '0, '0, 48'd8));
        settle();
        write_reg(wdh_pkg::REG_BINS_IN_USE, 32'd1);
        write_reg(wdh_pkg::REG_HALF_WINDOW, 32'd1);
        write_reg(wdh_pkg::REG_BIN_INVERSE, 32'd0);
        write_reg(wdh_pkg::REG_BOX_LOW, 32'h7FFF_FFFF);
        write_reg(wdh_pkg::REG_GROUP_BITS, 32'hFFFF_FFFF);
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd20));
        word_q.push_back(mk(wdh_pkg::OP_PARTICLE, 32'h8000_0000, 32'd4, '0));
        word_q.push_back(mk(wdh_pkg::OP_STEP, '0, '0, 48'd21));
        settle();

        // Random phases with varied register settings
        for (phase = 0; phase < 8; phase++)
        begin
            drain_all = (phase == 3);
            write_reg(wdh_pkg::REG_GROUP_BITS, (phase == 0) ? 32'd0 : rnd32() | 32'h1);
            write_reg(wdh_pkg::REG_BOX_LOW,
                      (phase == 1) ? 32'h8000_0000 : 32'(-$urandom_range(65536)));
            write_reg(wdh_pkg::REG_BIN_INVERSE, (phase == 2) ? 32'hFFFF_FFFF :
                      32'($urandom_range(4096, 262144)));
            write_reg(wdh_pkg::REG_BINS_IN_USE,
                      (phase == 4) ? 32'd127 : 32'($urandom_range(1, 64)));
            write_reg(wdh_pkg::REG_SAMPLE_PERIOD, (phase == 5) ? 32'hFFFF_FFFF :
                      32'($urandom_range(50, 5000)));
            write_reg(wdh_pkg::REG_HALF_WINDOW,
                      (phase == 6) ? 32'hFFFF : 32'($urandom_range(2, 20)));
            for (int n = 0; n < 4; n++)
            begin
                m = longint'(cfg_m.sample_period) * $urandom_range(1, 1000);
                if (cfg_m.half_window > 100) m = m + 70000;
                queue_window(m, $urandom_range(1, 4));
                if ($urandom_range(4) == 0)
                    word_q.push_back(mk(wdh_pkg::wdh_op_t'($urandom_range(3)), rnd32(),
                                        rnd32(), rnd48()));
            end
            settle();
        end

        drain_all = 1'b1;
        settle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
